### sv/sliding_window_vwap_macros.svh
// Assertion macros for the sliding window VWAP block.
// Used by the top level only; no dependencies.
`ifndef SLIDING_WINDOW_VWAP_MACROS_SVH
`define SLIDING_WINDOW_VWAP_MACROS_SVH
`define SWV_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SWV_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### sv/swvwap_pkg.sv
// Shared constants and types for the sliding window VWAP block.
// No dependencies.
package swvwap_pkg;
   localparam int RING_DEPTH_DEF    = 4096;
   localparam int FRACTION_BITS_DEF = 8;
   localparam int PRICE_W  = 24;
   localparam int VOL_W    = 28;
   localparam int TIME_W   = 63;
   localparam int AVG_W    = 32;
   localparam int SUMV_W   = 40;
   localparam int SUMPV_W  = 64;
   localparam int CNT_W    = 13;
   localparam logic [TIME_W-1:0] WINDOW_RESET = 63'd60000000000;

   typedef struct packed {
      logic [PRICE_W-1:0] trade_price;
      logic [VOL_W-1:0]   trade_volume;
      logic [TIME_W-1:0]  trade_time;
   } trade_type;

   typedef struct packed {
      logic [AVG_W-1:0]  average_price;
      logic [SUMV_W-1:0] window_volume;
      logic [CNT_W-1:0]  entries_held;
      logic              capacity_evicted;
   } result_type;

   typedef struct packed {
      logic               start;
      logic [SUMPV_W-1:0] dividend;
      logic [SUMV_W-1:0]  divisor;
   } div_req_type;
endpackage

### sv/swvwap_if.sv
// Valid/ready channel interfaces for trades, results and the window register.
// Depends on swvwap_pkg.
interface swvwap_trade_if;
   import swvwap_pkg::*;
   logic      valid;
   logic      ready;
   trade_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface swvwap_result_if;
   import swvwap_pkg::*;
   logic       valid;
   logic       ready;
   result_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface swvwap_csr_if;
   import swvwap_pkg::*;
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### sv/swvwap_ring.sv
// Trade ring memory: one write port, one registered read port.
// Depends on swvwap_pkg.
module swvwap_ring #(
   parameter int RING_DEPTH = swvwap_pkg::RING_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(RING_DEPTH)-1:0] wr_addr,
   input  swvwap_pkg::trade_type         wr_data,
   input  logic [$clog2(RING_DEPTH)-1:0] rd_addr,
   output swvwap_pkg::trade_type         rd_data
);
   import swvwap_pkg::*;
   trade_type mem [RING_DEPTH];
   trade_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

### sv/swvwap_div.sv
// Radix-2 restoring divider: quotient = (dividend << FRACTION_BITS) / divisor,
// saturated to the average width. Depends on swvwap_pkg.
module swvwap_div #(
   parameter int FRACTION_BITS = swvwap_pkg::FRACTION_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  swvwap_pkg::div_req_type       req,
   output logic                          done,
   output logic [swvwap_pkg::AVG_W-1:0]  quotient
);
   import swvwap_pkg::*;
   localparam int NUM_W = SUMPV_W + FRACTION_BITS;
   localparam int STEP_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [SUMV_W:0]   rem_ff, rem_in;
   logic [SUMV_W-1:0] den_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [SUMV_W:0]   trial;

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = '0;
      if (req.start) begin
         num_in  = {req.dividend, {FRACTION_BITS{1'b0}}};
         quo_in  = '0;
         rem_in  = '0;
         step_in = STEP_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         trial   = {rem_ff[SUMV_W-1:0], num_ff[NUM_W-1]};
         num_in  = {num_ff[NUM_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (req.start) begin
         den_ff <= req.divisor;
      end
   end

   assign done = done_ff;
   // saturate when the quotient spills past the output width
   assign quotient = (quo_ff[NUM_W-1:AVG_W] != '0) ? {AVG_W{1'b1}} : quo_ff[AVG_W-1:0];
endmodule

### sv/sliding_window_vwap.sv
// Channel     | dir | word                                       | accepted when
// req_trade   | in  | trade_price, trade_volume, trade_time      | valid && ready
// rsp_result  | out | average_price, window_volume, entries_held | valid && ready
// csr_window  | in  | window_length (63 bits)                    | valid && ready
// From trade accept to result valid: read and check the oldest ring entry, drop each
//   expired trade in turn and, on a capacity eviction, the oldest one, append the trade,
//   then run the bit-serial divider. The next trade is taken in the cycle after the result word is accepted.
// Reset clears sums, count and pointers and reloads the window; the ring is not cleared.
// The result sits in an output register; a stalled rsp holds that word and no trade is
// taken until it has been accepted.
`include "sliding_window_vwap_macros.svh"
module sliding_window_vwap #(
   parameter int RING_DEPTH    = swvwap_pkg::RING_DEPTH_DEF,
   parameter int FRACTION_BITS = swvwap_pkg::FRACTION_BITS_DEF
) (
   input logic clock,
   input logic reset,
   swvwap_trade_if.sink    req_trade,
   swvwap_result_if.source rsp_result,
   swvwap_csr_if.sink      csr_window
);
   import swvwap_pkg::*;
   localparam int AW = $clog2(RING_DEPTH);
   localparam int HW = $clog2(RING_DEPTH + 1);
   localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_CHECK = 3'd2,
                          ST_MUL = 3'd3, ST_APPEND = 3'd4, ST_DIV = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [TIME_W-1:0]  window_ff;
   trade_type          trade_ff, trade_in;
   logic [TIME_W-1:0]  cutoff_ff, cutoff_in;
   logic [AW-1:0]      oldest_ff, oldest_in;
   logic [HW-1:0]      held_ff, held_in;
   logic [SUMPV_W-1:0] spv_ff, spv_in;
   logic [SUMV_W-1:0]  sv_ff, sv_in;
   logic               evict_ff, evict_in;
   logic [51:0]        prod_ff, prod_in;
   logic               out_valid_ff, out_valid_in;
   result_type         out_ff, out_in;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   trade_type          rd_data;
   div_req_type        div_req;
   logic               div_done;
   logic [AVG_W-1:0]   div_q;
   logic [AW:0]        wr_sum;

   swvwap_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(trade_ff),
      .rd_addr(oldest_ff), .rd_data(rd_data)
   );

   swvwap_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
      .clock(clock), .reset(reset), .req(div_req), .done(div_done), .quotient(div_q)
   );

   assign req_trade.ready  = (state_ff == ST_IDLE) && !out_valid_ff;
   assign csr_window.ready = 1'b1;
   assign rsp_result.valid   = out_valid_ff;
   assign rsp_result.payload = out_ff;
   assign wr_sum  = {1'b0, oldest_ff} + (AW+1)'(held_ff);
   // wrap the append slot at the ring depth
   assign wr_addr = (wr_sum >= (AW+1)'(RING_DEPTH)) ? AW'(wr_sum - (AW+1)'(RING_DEPTH))
                                                    : wr_sum[AW-1:0];
   assign wr_en   = (state_ff == ST_APPEND);

   always_comb begin
      state_in     = state_ff;
      trade_in     = trade_ff;
      cutoff_in    = cutoff_ff;
      oldest_in    = oldest_ff;
      held_in      = held_ff;
      spv_in       = spv_ff;
      sv_in        = sv_ff;
      evict_in     = evict_ff;
      prod_in      = prod_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp_result.ready;
      div_req      = '{start: 1'b0, dividend: spv_ff, divisor: sv_ff};
      case (state_ff)
         ST_IDLE: begin
            if (req_trade.valid && req_trade.ready) begin
               trade_in  = req_trade.payload;
               cutoff_in = (req_trade.payload.trade_time >= window_ff)
                           ? req_trade.payload.trade_time - window_ff : '0;
               evict_in  = 1'b0;
               state_in  = ST_READ;
            end
         end
         ST_READ: begin
            // ring read of the oldest slot lands next cycle
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            prod_in = 52'(rd_data.trade_price) * 52'(rd_data.trade_volume);
            if (held_ff != '0 && rd_data.trade_time < cutoff_ff) begin
               state_in = ST_MUL;
            end else if (held_ff == HW'(RING_DEPTH)) begin
               evict_in = 1'b1;
               state_in = ST_MUL;
            end else begin
               state_in = ST_APPEND;
            end
         end
         ST_MUL: begin
            // drop the oldest word, then look at the next one or, on a capacity eviction, append
            spv_in    = spv_ff - SUMPV_W'(prod_ff);
            sv_in     = sv_ff - SUMV_W'(rd_data.trade_volume);
            oldest_in = (oldest_ff == AW'(RING_DEPTH - 1)) ? '0 : oldest_ff + AW'(1);
            held_in   = held_ff - HW'(1);
            state_in  = evict_ff ? ST_APPEND : ST_READ;
         end
         ST_APPEND: begin
            held_in  = held_ff + HW'(1);
            spv_in   = spv_ff + SUMPV_W'(52'(trade_ff.trade_price) * 52'(trade_ff.trade_volume));
            sv_in    = sv_ff + SUMV_W'(trade_ff.trade_volume);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               out_in.average_price    = (sv_ff == '0) ? '0 : div_q;
               out_in.window_volume    = sv_ff;
               out_in.entries_held     = CNT_W'(held_ff);
               out_in.capacity_evicted = evict_ff;
               out_valid_in            = 1'b1;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (state_ff == ST_APPEND) begin
         div_req.start = 1'b1;
      end
      div_req.dividend = spv_in;
      div_req.divisor  = sv_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         window_ff    <= WINDOW_RESET;
         oldest_ff    <= '0;
         held_ff      <= '0;
         spv_ff       <= '0;
         sv_ff        <= '0;
         evict_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         held_ff      <= held_in;
         spv_ff       <= spv_in;
         sv_ff        <= sv_in;
         evict_ff     <= evict_in;
         out_valid_ff <= out_valid_in;
         if (csr_window.valid && csr_window.ready) begin
            window_ff <= csr_window.payload;
         end
      end
      trade_ff  <= trade_in;
      cutoff_ff <= cutoff_in;
      prod_ff   <= prod_in;
      out_ff    <= out_in;
   end

   `SWV_ASSERT_IMPL(a_held_bound, clock, reset, 1'b1, held_ff <= HW'(RING_DEPTH), "held count above depth")
   `SWV_ASSERT_NEXT(a_append_grows, clock, reset, state_ff == ST_APPEND, held_ff == $past(held_ff) + HW'(1), "append did not count")
   `SWV_ASSERT_IMPL(a_zero_vol, clock, reset, out_valid_ff && out_ff.window_volume == '0, out_ff.average_price == '0, "nonzero average with no volume")
   `SWV_ASSERT_IMPL(a_no_accept_busy, clock, reset, state_ff != ST_IDLE, !req_trade.ready, "trade accepted while busy")
endmodule
